// ----- design/sfrl_pkg.sv -----
// Shared constants, codes and types of the serial frame receiver.
package sfrl_pkg;

	localparam int PAYLOAD_DEPTH = 256;
	localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic [7:0] CHECK_SEED = 8'h33;

	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_RELEASE = 2'd3;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_DISCARD = 3'd2;
	localparam logic [2:0] ST_ACCEPT = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_TIMEOUT = 3'd1;
	localparam logic [2:0] ERR_LENGTH = 3'd2;
	localparam logic [2:0] ERR_XOR = 3'd3;
	localparam logic [2:0] ERR_SUM = 3'd4;
	localparam logic [2:0] ERR_OWN_SRC = 3'd5;
	localparam logic [2:0] ERR_DEST = 3'd6;

	localparam logic [2:0] REG_EXT_MODE = 3'd0;
	localparam logic [2:0] REG_HEAD = 3'd1;
	localparam logic [2:0] REG_SIGNAL = 3'd2;
	localparam logic [2:0] REG_ACK_HEAD = 3'd3;
	localparam logic [2:0] REG_OWN_NODE = 3'd4;
	localparam logic [2:0] REG_BCAST = 3'd5;
	localparam logic [2:0] REG_TIMEOUT = 3'd6;
	localparam logic [2:0] REG_CMD_TYPE = 3'd7;

	typedef struct packed {
		logic        extended_mode;
		logic [7:0]  head_byte;
		logic [7:0]  signal_byte;
		logic [7:0]  ack_head_byte;
		logic [7:0]  own_node;
		logic [7:0]  broadcast_node;
		logic [15:0] char_timeout;
		logic [7:0]  command_type;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] error_kind;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic       frame_ready;
		logic [7:0] payload_length;
		logic [7:0] source_node;
		logic [7:0] dest_addr;
		logic [7:0] frame_type;
		logic [7:0] read_data;
		logic       signal_seen;
	} res_t;

endpackage

// ----- design/sfrl_intf.sv -----
// Request and result channel interfaces of the serial frame receiver.
interface sfrl_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	logic [7:0] read_index;
	logic       sender_waiting;

	modport source(output valid, action, rx_byte, read_index, sender_waiting, input ready);
	modport sink(input valid, action, rx_byte, read_index, sender_waiting, output ready);
endinterface

interface sfrl_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [2:0] error_kind;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       last;
	logic       frame_ready;
	logic [7:0] payload_length;
	logic [7:0] source_node;
	logic [7:0] dest_addr;
	logic [7:0] frame_type;
	logic [7:0] read_data;
	logic       signal_seen;

	modport source(output valid, status, error_kind, tx_valid, tx_byte, last, frame_ready,
		payload_length, source_node, dest_addr, frame_type, read_data, signal_seen,
		input ready);
	modport sink(input valid, status, error_kind, tx_valid, tx_byte, last, frame_ready,
		payload_length, source_node, dest_addr, frame_type, read_data, signal_seen,
		output ready);
endinterface

// ----- design/sfrl_cfg.sv -----
// APB configuration registers of the serial frame receiver.
module sfrl_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sfrl_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sfrl_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sfrl_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output sfrl_pkg::cfg_t                   cfg
);

	sfrl_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extended_mode <= 1'b1;
			cfg_q.head_byte <= 8'h02;
			cfg_q.signal_byte <= 8'h05;
			cfg_q.ack_head_byte <= 8'h06;
			cfg_q.own_node <= 8'h01;
			cfg_q.broadcast_node <= 8'hFF;
			cfg_q.char_timeout <= 16'd100;
			cfg_q.command_type <= 8'h00;
		end else if (wr_en) begin
			unique case (reg_idx)
				sfrl_pkg::REG_EXT_MODE: cfg_q.extended_mode <= pwdata[0];
				sfrl_pkg::REG_HEAD:     cfg_q.head_byte <= pwdata[7:0];
				sfrl_pkg::REG_SIGNAL:   cfg_q.signal_byte <= pwdata[7:0];
				sfrl_pkg::REG_ACK_HEAD: cfg_q.ack_head_byte <= pwdata[7:0];
				sfrl_pkg::REG_OWN_NODE: cfg_q.own_node <= pwdata[7:0];
				sfrl_pkg::REG_BCAST:    cfg_q.broadcast_node <= pwdata[7:0];
				sfrl_pkg::REG_TIMEOUT:  cfg_q.char_timeout <= pwdata[15:0];
				sfrl_pkg::REG_CMD_TYPE: cfg_q.command_type <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			sfrl_pkg::REG_EXT_MODE: prdata = {31'd0, cfg_q.extended_mode};
			sfrl_pkg::REG_HEAD:     prdata = {24'd0, cfg_q.head_byte};
			sfrl_pkg::REG_SIGNAL:   prdata = {24'd0, cfg_q.signal_byte};
			sfrl_pkg::REG_ACK_HEAD: prdata = {24'd0, cfg_q.ack_head_byte};
			sfrl_pkg::REG_OWN_NODE: prdata = {24'd0, cfg_q.own_node};
			sfrl_pkg::REG_BCAST:    prdata = {24'd0, cfg_q.broadcast_node};
			sfrl_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg_q.char_timeout};
			sfrl_pkg::REG_CMD_TYPE: prdata = {24'd0, cfg_q.command_type};
			default:                prdata = '0;
		endcase
	end

endmodule

// ----- design/sfrl_store.sv -----
// Payload memory with registered read and same-edge write bypass.
module sfrl_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [7:0]          rd_addr,
	input  sfrl_pkg::wr_t       wr,
	output logic [7:0]          rd_data
);

	logic [7:0]                  mem [sfrl_pkg::PAYLOAD_DEPTH];
	logic [7:0]                  rd_q;
	logic [7:0]                  byp_q;
	logic                        hit_q;
	logic                        range_q;
	logic [sfrl_pkg::ADDR_W-1:0] rd_idx;
	logic                        in_range;

	assign rd_idx = rd_addr[sfrl_pkg::ADDR_W-1:0];
	assign in_range = {1'b0, rd_addr} < 9'(sfrl_pkg::PAYLOAD_DEPTH);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_idx];
			byp_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			range_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr.en && (wr.addr == rd_idx);
			range_q <= in_range;
		end
	end

	assign rd_data = !range_q ? 8'd0 : (hit_q ? byp_q : rd_q);

endmodule

// ----- design/sfrl_core.sv -----
// Request stage, frame state machine with running checks, and result register.
module sfrl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  sfrl_pkg::cfg_t    cfg,
	sfrl_req_if.sink          req,
	sfrl_rsp_if.source        rsp
);

	localparam logic [3:0] PH_HEAD = 4'd0;
	localparam logic [3:0] PH_LEN  = 4'd1;
	localparam logic [3:0] PH_SRC  = 4'd2;
	localparam logic [3:0] PH_DST  = 4'd3;
	localparam logic [3:0] PH_TYPE = 4'd4;
	localparam logic [3:0] PH_DATA = 4'd5;
	localparam logic [3:0] PH_CHK1 = 4'd6;
	localparam logic [3:0] PH_CHK2 = 4'd7;
	localparam logic [3:0] PH_HELD = 4'd8;

	// request stage
	logic       valid_s1;
	logic [1:0] act_s1;
	logic [7:0] byte_s1;
	logic       wait_s1;

	// frame state
	logic [3:0]  phase_q, phase_n;
	logic [7:0]  explen_q, explen_n;
	logic [7:0]  wp_q, wp_n;
	logic [7:0]  src_q, src_n;
	logic [7:0]  dst_q, dst_n;
	logic [7:0]  kind_q, kind_n;
	logic [7:0]  xor_q, xor_n;
	logic [7:0]  sum_q, sum_n;
	logic [15:0] gap_q, gap_n;
	logic        sig_q, sig_n;

	// result register
	logic              out_valid_q;
	logic              ack2_q;
	sfrl_pkg::res_t    res_q;
	sfrl_pkg::res_t    res_n;

	logic          req_acc;
	logic          advance;
	logic          take;
	logic          two;
	logic [2:0]    status;
	logic [2:0]    err;
	logic          txv;
	logic [7:0]    txb;
	logic [7:0]    hdr;
	logic [8:0]    plen;
	logic [7:0]    rd_data;
	sfrl_pkg::wr_t wr;

	assign advance = valid_s1 && (!out_valid_q || (rsp.ready && !ack2_q));
	assign req.ready = !valid_s1 || advance;
	assign req_acc = req.valid && req.ready;

	sfrl_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_acc),
		.rd_addr (req.read_index),
		.wr      (wr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			act_s1 <= req.action;
			byte_s1 <= req.rx_byte;
			wait_s1 <= req.sender_waiting;
		end
	end

	assign hdr = cfg.extended_mode ? 8'd3 : 8'd2;
	assign plen = {1'b0, byte_s1} - {1'b0, hdr};

	always_comb begin
		phase_n = phase_q;
		explen_n = explen_q;
		wp_n = wp_q;
		src_n = src_q;
		dst_n = dst_q;
		kind_n = kind_q;
		xor_n = xor_q;
		sum_n = sum_q;
		gap_n = gap_q;
		sig_n = sig_q;
		status = sfrl_pkg::ST_NONE;
		err = sfrl_pkg::ERR_NONE;
		txv = 1'b0;
		txb = 8'd0;
		two = 1'b0;
		take = 1'b0;
		wr.en = 1'b0;
		wr.addr = wp_q[sfrl_pkg::ADDR_W-1:0];
		wr.data = byte_s1;
		unique case (act_s1)
			sfrl_pkg::ACT_TICK: begin
				if (gap_q != 16'd0) gap_n = gap_q - 16'd1;
			end
			sfrl_pkg::ACT_READ: begin
				status = sfrl_pkg::ST_READ;
			end
			sfrl_pkg::ACT_RELEASE: begin
				phase_n = PH_HEAD;
			end
			sfrl_pkg::ACT_BYTE: begin
				if (phase_q == PH_HELD || wait_s1) begin
					status = sfrl_pkg::ST_REFUSED;
				end else if (phase_q != PH_HEAD && gap_q == 16'd0) begin
					phase_n = PH_HEAD;
					status = sfrl_pkg::ST_DISCARD;
					err = sfrl_pkg::ERR_TIMEOUT;
				end else begin
					take = 1'b1;
					unique case (phase_q)
						PH_HEAD: begin
							if (byte_s1 != cfg.head_byte) begin
								take = 1'b0;
								if (byte_s1 == cfg.signal_byte) sig_n = 1'b1;
							end else begin
								phase_n = PH_LEN;
							end
						end
						PH_LEN: begin
							if (byte_s1 <= hdr || plen > 9'(sfrl_pkg::PAYLOAD_DEPTH)) begin
								take = 1'b0;
								phase_n = PH_HEAD;
								status = sfrl_pkg::ST_DISCARD;
								err = sfrl_pkg::ERR_LENGTH;
							end else begin
								explen_n = plen[7:0];
								phase_n = PH_SRC;
							end
						end
						PH_SRC: begin
							src_n = byte_s1;
							xor_n = sfrl_pkg::CHECK_SEED ^ byte_s1;
							sum_n = sfrl_pkg::CHECK_SEED + byte_s1;
							phase_n = PH_DST;
						end
						PH_DST: begin
							dst_n = byte_s1;
							xor_n = xor_q ^ byte_s1;
							sum_n = sum_q + byte_s1;
							if (cfg.extended_mode) begin
								phase_n = PH_TYPE;
							end else begin
								kind_n = cfg.command_type;
								wp_n = 8'd0;
								phase_n = PH_DATA;
							end
						end
						PH_TYPE: begin
							kind_n = byte_s1;
							xor_n = xor_q ^ byte_s1;
							sum_n = sum_q + byte_s1;
							wp_n = 8'd0;
							phase_n = PH_DATA;
						end
						PH_DATA: begin
							wr.en = {1'b0, wp_q} < 9'(sfrl_pkg::PAYLOAD_DEPTH);
							xor_n = xor_q ^ byte_s1;
							sum_n = sum_q + byte_s1;
							wp_n = wp_q + 8'd1;
							if (wp_n == explen_q) phase_n = PH_CHK1;
						end
						PH_CHK1: begin
							if (byte_s1 != xor_q) begin
								take = 1'b0;
								phase_n = PH_HEAD;
								status = sfrl_pkg::ST_DISCARD;
								err = sfrl_pkg::ERR_XOR;
							end else begin
								phase_n = PH_CHK2;
							end
						end
						PH_CHK2: begin
							take = 1'b0;
							phase_n = PH_HEAD;
							status = sfrl_pkg::ST_DISCARD;
							if (byte_s1 != sum_q) begin
								err = sfrl_pkg::ERR_SUM;
							end else if (src_q == cfg.own_node) begin
								err = sfrl_pkg::ERR_OWN_SRC;
							end else if (dst_q != cfg.own_node && dst_q != cfg.broadcast_node) begin
								err = sfrl_pkg::ERR_DEST;
							end else begin
								phase_n = PH_HELD;
								status = sfrl_pkg::ST_ACCEPT;
								txv = 1'b1;
								txb = cfg.ack_head_byte;
								two = 1'b1;
							end
						end
						default: begin
							take = 1'b0;
							phase_n = PH_HEAD;
							status = sfrl_pkg::ST_DISCARD;
						end
					endcase
					if (take) gap_n = cfg.char_timeout;
				end
			end
		endcase
		if (!advance) wr.en = 1'b0;

		res_n.status = status;
		res_n.error_kind = err;
		res_n.tx_valid = txv;
		res_n.tx_byte = txb;
		res_n.last = !two;
		res_n.frame_ready = (phase_n == PH_HELD);
		res_n.payload_length = explen_n;
		res_n.source_node = src_n;
		res_n.dest_addr = dst_n;
		res_n.frame_type = kind_n;
		res_n.read_data = (act_s1 == sfrl_pkg::ACT_READ) ? rd_data : 8'd0;
		res_n.signal_seen = sig_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			explen_q <= 8'd0;
			wp_q <= 8'd0;
			src_q <= 8'd0;
			dst_q <= 8'd0;
			kind_q <= 8'd0;
			xor_q <= 8'd0;
			sum_q <= 8'd0;
			gap_q <= 16'd0;
			sig_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			explen_q <= explen_n;
			wp_q <= wp_n;
			src_q <= src_n;
			dst_q <= dst_n;
			kind_q <= kind_n;
			xor_q <= xor_n;
			sum_q <= sum_n;
			gap_q <= gap_n;
			sig_q <= sig_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ack2_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			ack2_q <= two;
		end else if (out_valid_q && rsp.ready) begin
			out_valid_q <= ack2_q;
			ack2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end else if (out_valid_q && rsp.ready && ack2_q) begin
			// second acknowledge byte
			res_q.tx_byte <= cfg.own_node;
			res_q.last <= 1'b1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = res_q.status;
	assign rsp.error_kind = res_q.error_kind;
	assign rsp.tx_valid = res_q.tx_valid;
	assign rsp.tx_byte = res_q.tx_byte;
	assign rsp.last = res_q.last;
	assign rsp.frame_ready = res_q.frame_ready;
	assign rsp.payload_length = res_q.payload_length;
	assign rsp.source_node = res_q.source_node;
	assign rsp.dest_addr = res_q.dest_addr;
	assign rsp.frame_type = res_q.frame_type;
	assign rsp.read_data = res_q.read_data;
	assign rsp.signal_seen = res_q.signal_seen;

endmodule

// ----- design/serial_frame_receiver_lrc_top.sv -----
// Top level of the serial frame receiver with XOR and additive check bytes.
// A request is held in the request stage, then its result in the result register.
// Throughput: one request per cycle while rsp.ready takes results; a valid frame
// yields two; its second acknowledge byte holds the result register until taken.
// Reset: arst_n asynchronously resets frame state, flags and config to defaults;
// data registers and payload memory are not cleared; memory needs no clearing pass.
module serial_frame_receiver_lrc_top (
	input  logic                            clk,
	input  logic                            arst_n,
	sfrl_req_if.sink                        req,
	sfrl_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sfrl_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sfrl_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sfrl_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	sfrl_pkg::cfg_t cfg;

	sfrl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfrl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
